[hw/rtl/multi_input_debounce_events_core_defines.svh]
// ----------------------------------------------------------------------------
// Debounce event core assertion macros
// Shared concurrent assertion forms for the debounce event core.
// ----------------------------------------------------------------------------
`ifndef MULTI_INPUT_DEBOUNCE_EVENTS_CORE_DEFINES_SVH
`define MULTI_INPUT_DEBOUNCE_EVENTS_CORE_DEFINES_SVH

// same-cycle implication, skipped while reset is high
`define MIDE_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed: same-cycle implication");

// next-cycle implication, skipped while reset is high
`define MIDE_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed: next-cycle implication");

`endif

[hw/rtl/mide_pkg.sv]
// ----------------------------------------------------------------------------
// Debounce event package
// Widths, codes, queue record types and helpers shared by the core modules.
// ----------------------------------------------------------------------------
package mide_pkg;

   localparam int MAX_CHANNELS = 16;
   localparam int LEVEL_W      = 16;
   localparam int TIMER_W      = 16;
   localparam int CHAN_W       = 4;
   localparam int QUEUE_DEPTH  = 2;
   localparam int QPTR_W       = $clog2(QUEUE_DEPTH);

   localparam logic [TIMER_W-1:0] DELAY_RESET = 16'd20;

   // item kind codes
   localparam logic KIND_SCAN = 1'b0;
   localparam logic KIND_LOAD = 1'b1;

   // one scan's outcome: channels that changed and the vector after the scan
   typedef struct packed {
      logic [LEVEL_W-1:0] changed;
      logic [LEVEL_W-1:0] levels;
   } scan_rec_type;

   typedef struct packed {
      logic         valid;
      scan_rec_type rec;
   } qport_type;

   function automatic logic [CHAN_W-1:0] lowest_set(input logic [LEVEL_W-1:0] mask);
      logic [CHAN_W-1:0] idx;
      idx = '0;
      for (int i = LEVEL_W - 1; i >= 0; i--) begin
         if (mask[i]) begin
            idx = CHAN_W'(i);
         end
      end
      return idx;
   endfunction

endpackage

[hw/rtl/multi_input_debounce_events_core.sv]
// An accepted scan that confirms changes reaches the outputs through the two-record
//   queue and the result register. Throughput: one item per cycle while the queue
//   is not full; a scan confirming k channels yields k events, one per cycle while popped.
// Reset: synchronous, active high; timers and confirmed vector clear to zero,
//   debounce delay returns to 20, queue and result register empty.
// ----------------------------------------------------------------------------
// Multi-input debounce event core
// Per-channel counter debouncer with change events, front end and event back
// end decoupled by a short record queue.
// ----------------------------------------------------------------------------
`include "multi_input_debounce_events_core_defines.svh"

module multi_input_debounce_events_core #(
   parameter int CHANNELS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic                             req_kind,
   input  logic [mide_pkg::LEVEL_W-1:0]     req_raw_levels,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [mide_pkg::CHAN_W-1:0]      rsp_channel,
   output logic                             rsp_new_level,
   output logic [mide_pkg::LEVEL_W-1:0]     rsp_confirmed_levels,
   output logic                             rsp_last,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mide_pkg::TIMER_W-1:0]     csr_data
);

   mide_pkg::qport_type q_wr, q_rd;
   logic                q_full, q_pop, back_busy;

   assign csr_ready = 1'b1;

   mide_front #(
      .CHANNELS (CHANNELS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_kind       (req_kind),
      .req_raw_levels (req_raw_levels),
      .csr_valid      (csr_valid && csr_ready),
      .csr_data       (csr_data),
      .q_full         (q_full),
      .q_wr           (q_wr)
   );

   mide_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_wr   (q_wr),
      .q_full (q_full),
      .q_rd   (q_rd),
      .q_pop  (q_pop)
   );

   mide_back u_back (
      .clock                (clock),
      .reset                (reset),
      .q_rd                 (q_rd),
      .q_pop                (q_pop),
      .back_busy            (back_busy),
      .rsp_empty            (rsp_empty),
      .rsp_pop              (rsp_pop),
      .rsp_channel          (rsp_channel),
      .rsp_new_level        (rsp_new_level),
      .rsp_confirmed_levels (rsp_confirmed_levels),
      .rsp_last             (rsp_last)
   );

   // a shown event that is not the last of its scan leaves more work in the back end
   `MIDE_ASSERT_IMPLY(a_more_pending, clock, reset, !rsp_empty && !rsp_last, back_busy)
   // taking a non-last event brings the next one of the same scan right away
   `MIDE_ASSERT_NEXT(a_no_gap, clock, reset, rsp_pop && !rsp_empty && !rsp_last, !rsp_empty)
   // a load item never creates an event record
   `MIDE_ASSERT_IMPLY(a_load_silent, clock, reset,
      req_push && !req_full && (req_kind == mide_pkg::KIND_LOAD), !q_wr.valid)

endmodule

[hw/rtl/mide_front.sv]
// ----------------------------------------------------------------------------
// Debounce front end
// Accepts scan and load items, runs the per-channel timers and pushes one
// record per scan that confirmed at least one change.
// ----------------------------------------------------------------------------
module mide_front #(
   parameter int CHANNELS = 16
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  logic                             req_kind,
   input  logic [mide_pkg::LEVEL_W-1:0]     req_raw_levels,
   input  logic                             csr_valid,
   input  logic [mide_pkg::TIMER_W-1:0]     csr_data,
   input  logic                             q_full,
   output mide_pkg::qport_type              q_wr
);

   localparam int NCH = (CHANNELS < mide_pkg::MAX_CHANNELS) ? CHANNELS
                                                            : mide_pkg::MAX_CHANNELS;
   localparam logic [mide_pkg::LEVEL_W-1:0] CHAN_MASK =
      mide_pkg::LEVEL_W'((33'd1 << NCH) - 33'd1);

   logic [mide_pkg::TIMER_W-1:0] delay_ff, delay_in;
   logic [mide_pkg::LEVEL_W-1:0] confirmed_ff, confirmed_in;
   logic [mide_pkg::LEVEL_W-1:0] raw_masked, diff, changed;
   logic [NCH-1:0]               hit;
   logic                         accept, is_load;

   assign req_full   = q_full;
   assign accept     = req_push && !q_full;
   assign is_load    = (req_kind == mide_pkg::KIND_LOAD);
   assign raw_masked = req_raw_levels & CHAN_MASK;
   assign diff       = raw_masked ^ confirmed_ff;
   assign changed    = mide_pkg::LEVEL_W'(hit);

   for (genvar g = 0; g < NCH; g++) begin : g_lane
      logic [mide_pkg::TIMER_W-1:0] timer_ff, timer_in, scan_next;
      logic                         scan_hit;

      always_comb begin
         scan_next = '0;
         scan_hit  = 1'b0;
         if (diff[g]) begin
            if (timer_ff == '0) begin
               scan_next = delay_ff;
            end else begin
               scan_next = timer_ff - mide_pkg::TIMER_W'(1);
               scan_hit  = (timer_ff == mide_pkg::TIMER_W'(1));
            end
         end
      end

      always_comb begin
         timer_in = timer_ff;
         if (accept) begin
            timer_in = is_load ? '0 : scan_next;
         end
      end

      assign hit[g] = scan_hit;

      always_ff @(posedge clock) begin
         if (reset) begin
            timer_ff <= '0;
         end else begin
            timer_ff <= timer_in;
         end
      end
   end

   always_comb begin
      confirmed_in = confirmed_ff;
      if (accept) begin
         // a confirmed change always flips the stored bit
         confirmed_in = is_load ? raw_masked : (confirmed_ff ^ changed);
      end
   end

   assign delay_in = csr_valid ? csr_data : delay_ff;

   always_comb begin
      q_wr.valid       = accept && !is_load && (changed != '0);
      q_wr.rec.changed = changed;
      q_wr.rec.levels  = confirmed_ff ^ changed;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         delay_ff     <= mide_pkg::DELAY_RESET;
         confirmed_ff <= '0;
      end else begin
         delay_ff     <= delay_in;
         confirmed_ff <= confirmed_in;
      end
   end

endmodule

[hw/rtl/mide_queue.sv]
// ----------------------------------------------------------------------------
// Scan record queue
// Short first-in first-out buffer of scan records between front and back.
// ----------------------------------------------------------------------------
module mide_queue (
   input  logic                clock,
   input  logic                reset,
   input  mide_pkg::qport_type q_wr,
   output logic                q_full,
   output mide_pkg::qport_type q_rd,
   input  logic                q_pop
);

   mide_pkg::scan_rec_type entry_ff [mide_pkg::QUEUE_DEPTH];

   logic [mide_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [mide_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [mide_pkg::QPTR_W:0]   count_ff, count_in;
   logic                        do_wr, do_rd;

   assign q_full = (count_ff == (mide_pkg::QPTR_W + 1)'(mide_pkg::QUEUE_DEPTH));
   assign do_wr  = q_wr.valid && !q_full;
   assign do_rd  = q_pop && (count_ff != '0);

   always_comb begin
      q_rd.valid = (count_ff != '0);
      q_rd.rec   = entry_ff[rd_ptr_ff];
   end

   always_comb begin
      wr_ptr_in = do_wr ? wr_ptr_ff + mide_pkg::QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_rd ? rd_ptr_ff + mide_pkg::QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr && !do_rd) begin
         count_in = count_ff + (mide_pkg::QPTR_W + 1)'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - (mide_pkg::QPTR_W + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= q_wr.rec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

[hw/rtl/mide_back.sv]
// ----------------------------------------------------------------------------
// Debounce event back end
// Walks each scan record's change mask lowest channel first and drives one
// change event per cycle into the result register while it is empty or being read.
// ----------------------------------------------------------------------------
module mide_back (
   input  logic                             clock,
   input  logic                             reset,
   input  mide_pkg::qport_type              q_rd,
   output logic                             q_pop,
   output logic                             back_busy,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output logic [mide_pkg::CHAN_W-1:0]      rsp_channel,
   output logic                             rsp_new_level,
   output logic [mide_pkg::LEVEL_W-1:0]     rsp_confirmed_levels,
   output logic                             rsp_last
);

   logic [mide_pkg::LEVEL_W-1:0] pend_ff, pend_in;
   logic [mide_pkg::LEVEL_W-1:0] levels_ff, levels_in;
   logic                         out_valid_ff, out_valid_in;
   logic [mide_pkg::CHAN_W-1:0]  chan_ff, chan_in;
   logic                         lvl_ff, lvl_in;
   logic [mide_pkg::LEVEL_W-1:0] conf_ff, conf_in;
   logic                         last_ff, last_in;

   logic                         out_free, src_valid, from_queue;
   logic [mide_pkg::LEVEL_W-1:0] src_mask, src_levels, rest;
   logic [mide_pkg::CHAN_W-1:0]  idx;

   assign back_busy  = (pend_ff != '0);
   assign out_free   = !out_valid_ff || rsp_pop;
   assign from_queue = !back_busy && q_rd.valid;
   assign src_valid  = back_busy || q_rd.valid;
   assign src_mask   = back_busy ? pend_ff : q_rd.rec.changed;
   assign src_levels = back_busy ? levels_ff : q_rd.rec.levels;
   assign idx        = mide_pkg::lowest_set(src_mask);
   // drop the lowest set bit
   assign rest       = src_mask & (src_mask - mide_pkg::LEVEL_W'(1));
   assign q_pop      = out_free && from_queue;

   always_comb begin
      pend_in      = pend_ff;
      levels_in    = levels_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      chan_in      = chan_ff;
      lvl_in       = lvl_ff;
      conf_in      = conf_ff;
      last_in      = last_ff;
      if (out_free && src_valid) begin
         pend_in      = rest;
         levels_in    = src_levels;
         out_valid_in = 1'b1;
         chan_in      = idx;
         lvl_in       = src_levels[idx];
         conf_in      = src_levels;
         last_in      = (rest == '0);
      end
   end

   always_ff @(posedge clock) begin
      levels_ff <= levels_in;
      chan_ff   <= chan_in;
      lvl_ff    <= lvl_in;
      conf_ff   <= conf_in;
      last_ff   <= last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_ff      <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         pend_ff      <= pend_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_empty            = !out_valid_ff;
   assign rsp_channel          = chan_ff;
   assign rsp_new_level        = lvl_ff;
   assign rsp_confirmed_levels = conf_ff;
   assign rsp_last             = last_ff;

endmodule
